@@ rtl/cais_pkg.sv @@
// ----------------------------------------------------------------------------
// cais_pkg
// Shared types, state codes, register indices, fixed-point constants and
// the square root step function of the infection probability stencil.
// ----------------------------------------------------------------------------
package cais_pkg;

  localparam int unsigned FracBits = 16;

  // floor(sqrt(0.5) * 2^16) and floor(2^16 / (8 * sqrt(2)))
  localparam logic [15:0] RootHalf = 16'd46340;
  localparam logic [15:0] DiagGain = 16'd5792;
  localparam logic [15:0] FracMax  = 16'hFFFF;

  localparam logic [3:0] StSusceptible  = 4'd1;
  localparam logic [3:0] StInfected     = 4'd3;
  localparam logic [3:0] StAsymptomatic = 4'd4;

  localparam logic RegGridColumns = 1'b0;
  localparam logic RegGridRows    = 1'b1;

  typedef struct packed {
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [3:0]  state;
    logic [15:0] term;
    logic [15:0] sirc;
  } cell_t;

  typedef struct packed {
    cell_t mid;
    cell_t up;
  } pair_t;

  // four digits of a bit-pair square root recurrence
  function automatic sqrt_t sqrt_step4(sqrt_t s);
    sqrt_t       o;
    logic [19:0] rw;
    logic [19:0] t;
    o = s;
    for (int i = 0; i < 4; i++) begin
      rw = {o.rem, o.rad[31:30]};
      t = {2'b00, o.root, 2'b01};
      o.rad = {o.rad[29:0], 2'b00};
      if (rw >= t) begin
        o.rem = 18'(rw - t);
        o.root = {o.root[14:0], 1'b1};
      end else begin
        o.rem = rw[17:0];
        o.root = {o.root[14:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

@@ rtl/ca_infection_probability_stencil.sv @@
// ----------------------------------------------------------------------------
// ca_infection_probability_stencil
// Streams grid cells in raster order and reports the infection probability
// of every interior cell from its 3x3 neighbourhood.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one cell word per cycle;
//   frame_start_i marks row 0, column 0 of a frame. Output channel
//   (out_valid_o/out_ready_i) gives one word per interior cell, one row and
//   one column behind the input. Border cells give no word.
//   Config channel (cfg_valid_i/cfg_ready_o) writes grid_columns (index 0)
//   and grid_rows (index 1); values are clamped to 3..GRID_MAX. Always ready.
//   Throughput: one cell per cycle while the output does not stall. The
//   result word passes the four square root stages, the neighbour term
//   register, the row store read/write pair, the window, sum, gain and
//   mix registers and the output register.
//   Reset: positions clear to row 0, column 0; sizes return to 256 (or
//   GRID_MAX); pipeline empties. Row stores hold no reset value.
//   Stall: when a word waits and out_ready_i is low, the whole pipeline
//   holds and in_ready_o drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ca_infection_probability_stencil #(
  parameter int unsigned GRID_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        frame_start_i,
  input  logic [3:0]  cell_state_i,
  input  logic [15:0] infectivity_i,
  input  logic [15:0] resistance_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  cell_row_o,
  output logic [7:0]  cell_column_o,
  output logic        was_susceptible_o,
  output logic [15:0] infection_probability_o
);

  localparam int unsigned CW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int unsigned SW = $clog2(GRID_MAX + 1);
  localparam int unsigned SizeRst = (GRID_MAX < 256) ? GRID_MAX : 256;

  typedef struct packed {
    logic          res;
    logic [SW-1:0] r;
    logic [SW-1:0] c;
  } meta_t;

  function automatic logic [SW-1:0] clamp_size(logic [8:0] v);
    if (v < 9'd3) return SW'(3);
    if (32'(v) > 32'(GRID_MAX)) return SW'(GRID_MAX);
    return SW'(v);
  endfunction

  logic          en;
  logic [SW-1:0] cols_q, rows_q;
  logic [SW-1:0] r_q, c_q, r_cur, c_cur, c_inc, r_inc, r_d, c_d;
  logic          acc;

  assign cfg_ready_o = 1'b1;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign acc = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= SW'(SizeRst);
      rows_q <= SW'(SizeRst);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cais_pkg::RegGridColumns) cols_q <= clamp_size(cfg_data_i);
      else rows_q <= clamp_size(cfg_data_i);
    end
  end

  always_comb begin
    r_cur = frame_start_i ? '0 : r_q;
    c_cur = frame_start_i ? '0 : c_q;
    c_inc = c_cur + 1'b1;
    r_inc = r_cur + 1'b1;
    r_d = r_cur;
    c_d = c_inc;
    if (c_inc >= cols_q) begin
      c_d = '0;
      r_d = (r_inc >= rows_q) ? '0 : r_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
    end else if (acc) begin
      r_q <= r_d;
      c_q <= c_d;
    end
  end

  // square root stages
  logic                v_sq_q [4];
  meta_t               m_sq_q [4];
  logic [3:0]          st_sq_q [4];
  cais_pkg::sqrt_t     sa_q [4];
  cais_pkg::sqrt_t     sb_q [4];
  cais_pkg::sqrt_t     sa_in, sb_in;
  logic [16:0]         irc_w;
  logic [15:0]         irc;
  meta_t               m_in;

  always_comb begin
    irc_w = 17'h10000 - {1'b0, resistance_i};
    irc = irc_w[16] ? cais_pkg::FracMax : irc_w[15:0];
    sa_in = '{rad: {infectivity_i, 16'h0000}, rem: '0, root: '0};
    sb_in = '{rad: {irc, 16'h0000}, rem: '0, root: '0};
    m_in.r = r_cur;
    m_in.c = c_cur;
    m_in.res = (r_cur >= SW'(2)) && (c_cur >= SW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) v_sq_q[k] <= 1'b0;
    end else if (en) begin
      v_sq_q[0] <= in_valid_i;
      for (int k = 1; k < 4; k++) v_sq_q[k] <= v_sq_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_sq_q[0] <= m_in;
      st_sq_q[0] <= cell_state_i;
      sa_q[0] <= cais_pkg::sqrt_step4(sa_in);
      sb_q[0] <= cais_pkg::sqrt_step4(sb_in);
      for (int k = 1; k < 4; k++) begin
        m_sq_q[k] <= m_sq_q[k-1];
        st_sq_q[k] <= st_sq_q[k-1];
        sa_q[k] <= cais_pkg::sqrt_step4(sa_q[k-1]);
        sb_q[k] <= cais_pkg::sqrt_step4(sb_q[k-1]);
      end
    end
  end

  // neighbour term
  logic            v_t_q;
  meta_t           m_t_q;
  cais_pkg::cell_t e_t_q;
  logic [31:0]     half_prod;
  logic [15:0]     term;

  always_comb begin
    half_prod = sa_q[3].root * cais_pkg::RootHalf;
    case (st_sq_q[3])
      cais_pkg::StInfected:     term = sa_q[3].root;
      cais_pkg::StAsymptomatic: term = half_prod[31:16];
      default:                  term = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_t_q <= 1'b0;
    else if (en) v_t_q <= v_sq_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_t_q <= m_sq_q[3];
      e_t_q <= '{state: st_sq_q[3], term: term, sirc: sb_q[3].root};
    end
  end

  // row stores: read at T, write back at A
  cais_pkg::pair_t mem [GRID_MAX];
  cais_pkg::pair_t rd_q, fwd_d_q, rd_eff, wr_d;
  logic            fwd_q;
  logic            v_a_q;
  meta_t           m_a_q;
  cais_pkg::cell_t e_a_q;

  assign rd_eff = fwd_q ? fwd_d_q : rd_q;
  assign wr_d = '{mid: e_a_q, up: rd_eff.mid};

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= mem[m_t_q.c[CW-1:0]];
      if (v_a_q) mem[m_a_q.c[CW-1:0]] <= wr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      fwd_q <= 1'b0;
    end else if (en) begin
      v_a_q <= v_t_q;
      fwd_q <= v_a_q && (m_t_q.c == m_a_q.c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_a_q <= m_t_q;
      e_a_q <= e_t_q;
      fwd_d_q <= wr_d;
    end
  end

  // 3x3 window
  cais_pkg::cell_t win_q [3][3];
  logic            v_w_q;
  meta_t           m_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_w_q <= 1'b0;
    else if (en) v_w_q <= v_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_w_q <= m_a_q;
      if (v_a_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= rd_eff.up;
        win_q[1][2] <= rd_eff.mid;
        win_q[2][2] <= e_a_q;
      end
    end
  end

  // sums
  logic        v_s_q, sus_s_q;
  meta_t       m_s_q;
  logic [17:0] so_s_q, sd_s_q;
  logic [15:0] sirc_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_s_q <= 1'b0;
    else if (en) v_s_q <= v_w_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_s_q <= m_w_q;
      sus_s_q <= (win_q[1][1].state == cais_pkg::StSusceptible);
      sirc_s_q <= win_q[1][1].sirc;
      so_s_q <= 18'(win_q[0][1].term) + 18'(win_q[1][0].term)
              + 18'(win_q[1][2].term) + 18'(win_q[2][1].term);
      sd_s_q <= 18'(win_q[0][0].term) + 18'(win_q[0][2].term)
              + 18'(win_q[2][0].term) + 18'(win_q[2][2].term);
    end
  end

  // diagonal gain
  logic        v_g_q, sus_g_q;
  meta_t       m_g_q;
  logic [14:0] so3_g_q;
  logic [33:0] dp_g_q;
  logic [15:0] sirc_g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_g_q <= 1'b0;
    else if (en) v_g_q <= v_s_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_g_q <= m_s_q;
      sus_g_q <= sus_s_q;
      sirc_g_q <= sirc_s_q;
      so3_g_q <= so_s_q[17:3];
      dp_g_q <= sd_s_q * cais_pkg::DiagGain;
    end
  end

  // mix
  logic        v_x_q, sus_x_q;
  meta_t       m_x_q;
  logic [17:0] mix_x_q;
  logic [15:0] sirc_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_x_q <= 1'b0;
    else if (en) v_x_q <= v_g_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_x_q <= m_g_q;
      sus_x_q <= sus_g_q;
      sirc_x_q <= sirc_g_q;
      mix_x_q <= 18'(so3_g_q) + 18'(dp_g_q[33:16]);
    end
  end

  // probability and output register
  logic [33:0] pp;
  logic [15:0] p;
  logic        out_valid_q;

  always_comb begin
    pp = sirc_x_q * mix_x_q;
    p = (pp[33:32] != 2'b00) ? cais_pkg::FracMax : pp[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v_x_q && m_x_q.res;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cell_row_o <= 8'(32'(m_x_q.r) - 32'd1);
      cell_column_o <= 8'(32'(m_x_q.c) - 32'd1);
      was_susceptible_o <= sus_x_q;
      infection_probability_o <= sus_x_q ? p : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ tb/tb_ca_infection_probability_stencil.sv @@
// ----------------------------------------------------------------------------
// tb_ca_infection_probability_stencil
// Streams grid frames of many sizes through the stencil and checks every
// interior-cell word against a cycle-free prediction of its neighbourhood
// math, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_ca_infection_probability_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        fs;
    logic [3:0]  st;
    logic [15:0] inf;
    logic [15:0] res;
  } cell_word_t;

  typedef struct {
    logic [7:0]  row;
    logic [7:0]  col;
    logic        sus;
    logic [15:0] prob;
  } prob_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = cais_pkg::RegGridColumns;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        frame_start_i = 1'b0;
  logic [3:0]  cell_state_i = '0;
  logic [15:0] infectivity_i = '0;
  logic [15:0] resistance_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  cell_row_o;
  logic [7:0]  cell_column_o;
  logic        was_susceptible_o;
  logic [15:0] infection_probability_o;

  ca_infection_probability_stencil u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cell_word_t  pending_cells[$];
  prob_word_t  expected_probs[$];
  cell_word_t  upper_line[256];
  cell_word_t  middle_line[256];
  cell_word_t  win[3][3];
  int unsigned pos_r = 0, pos_c = 0, grid_cols = 256, grid_rows = 256;
  int unsigned errors = 0, cells_sent = 0, words_seen = 0, sus_seen = 0, frames = 0;
  int unsigned gap_left = 0, hold_left = 0, long_left = 0;
  bit          long_done = 0, quiet_tx = 0, quiet_rx = 0;
  cell_word_t  cur_word;

  function automatic longint unsigned isqrt_q(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned spread_term(cell_word_t w);
    longint unsigned s;
    s = isqrt_q(longint'(w.inf) << 16);
    if (w.st == cais_pkg::StInfected) return s;
    if (w.st == cais_pkg::StAsymptomatic) return (s * cais_pkg::RootHalf) >> 16;
    return 0;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return v;
  endfunction

  task automatic predict_cell(cell_word_t w);
    cell_word_t      up, md;
    int unsigned     r, c;
    longint unsigned so, sd, mix, irc, p;
    prob_word_t      e;
    if (w.fs) begin
      pos_r = 0;
      pos_c = 0;
    end
    r = pos_r;
    c = pos_c;
    if (c >= 256) c = 0;
    up = upper_line[c];
    md = middle_line[c];
    upper_line[c] = md;
    middle_line[c] = w;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = md;
    win[2][2] = w;
    if (r >= 2 && c >= 2) begin
      p = 0;
      e.sus = (win[1][1].st == cais_pkg::StSusceptible);
      if (e.sus) begin
        so = spread_term(win[0][1]) + spread_term(win[1][0]) +
             spread_term(win[1][2]) + spread_term(win[2][1]);
        sd = spread_term(win[0][0]) + spread_term(win[0][2]) +
             spread_term(win[2][0]) + spread_term(win[2][2]);
        mix = (so >> 3) + ((sd * cais_pkg::DiagGain) >> 16);
        irc = 65536 - win[1][1].res;
        if (irc > 65535) irc = 65535;
        p = (isqrt_q(irc << 16) * mix) >> 16;
        if (p > 65535) p = 65535;
      end
      e.row = 8'(r - 1);
      e.col = 8'(c - 1);
      e.prob = 16'(p);
      expected_probs.push_back(e);
    end
    c++;
    if (c >= grid_cols) begin
      c = 0;
      r++;
      if (r >= grid_rows) r = 0;
    end
    pos_r = r;
    pos_c = c;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_cell(cur_word);
        cells_sent++;
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the word
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cells.size() > 0) begin
        cur_word = pending_cells.pop_front();
        in_valid_i <= 1'b1;
        frame_start_i <= cur_word.fs;
        cell_state_i <= cur_word.st;
        infectivity_i <= cur_word.inf;
        resistance_i <= cur_word.res;
        gap_left <= quiet_tx ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic report(string what, int unsigned exp_v, int unsigned act_v);
    errors++;
    if (errors <= 10)
      $display("MISMATCH %s: expected %0d, got %0d", what, exp_v, act_v);
  endtask

  // long receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (long_left > 0) begin
        long_left <= long_left - 1;
      end else if (!long_done && words_seen >= 40) begin
        long_done <= 1'b1;
        long_left <= 300;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    int unsigned h;
    prob_word_t  e;
    if (rst_ni) begin
      h = hold_left;
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        if (was_susceptible_o) sus_seen++;
        h = quiet_rx ? 0 : $urandom_range(0, 3);
        if (expected_probs.size() == 0) begin
          report("unexpected word at row", 0, cell_row_o);
        end else begin
          e = expected_probs.pop_front();
          if (cell_row_o !== e.row) report("cell_row", e.row, cell_row_o);
          if (cell_column_o !== e.col) report("cell_column", e.col, cell_column_o);
          if (was_susceptible_o !== e.sus) report("was_susceptible", e.sus, was_susceptible_o);
          if (infection_probability_o !== e.prob)
            report("infection_probability", e.prob, infection_probability_o);
        end
      end
      if (long_left > 0) begin
        hold_left <= h;
        out_ready_i <= 1'b0;
      end else if (h > 0) begin
        hold_left <= h - 1;
        out_ready_i <= 1'b0;
      end else begin
        hold_left <= 0;
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic idx, logic [8:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == cais_pkg::RegGridColumns) grid_cols = clamp_dim(data);
    else grid_rows = clamp_dim(data);
  endtask

  task automatic drain;
    while (pending_cells.size() > 0 || in_valid_i || expected_probs.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic push_cell(logic fs, logic [3:0] st, logic [15:0] inf, logic [15:0] res);
    cell_word_t w;
    w.fs = fs;
    w.st = st;
    w.inf = inf;
    w.res = res;
    pending_cells.push_back(w);
  endtask

  function automatic logic [15:0] rand_frac();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] rand_state();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 3) return cais_pkg::StSusceptible;
    if (k < 5) return cais_pkg::StInfected;
    if (k == 5) return cais_pkg::StAsymptomatic;
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic push_frame(logic fs, int unsigned ncells);
    for (int unsigned i = 0; i < ncells; i++)
      push_cell(i == 0 ? fs : 1'b0, rand_state(), rand_frac(), rand_frac());
    frames++;
  endtask

  task automatic run_phase(logic [8:0] cols_raw, logic [8:0] rows_raw);
    int unsigned n, nfr;
    bit          cut;
    drain();
    write_reg(cais_pkg::RegGridColumns, cols_raw);
    write_reg(cais_pkg::RegGridRows, rows_raw);
    quiet_tx = ($urandom_range(0, 3) == 0);
    quiet_rx = ($urandom_range(0, 3) == 0);
    cut = 1;
    nfr = (grid_cols * grid_rows > 256) ? 1 : $urandom_range(1, 3);
    for (int unsigned f = 0; f < nfr; f++) begin
      n = grid_cols * grid_rows;
      push_frame(cut || $urandom_range(0, 1), n);
      cut = 0;
      if ($urandom_range(0, 5) == 0) begin
        push_frame(1'b1, $urandom_range(1, n - 1));
        cut = 1;
      end
    end
  endtask

  initial begin
    logic [8:0] c, r;
    int unsigned k;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: 3x3 frames around one susceptible centre
    write_reg(cais_pkg::RegGridColumns, 9'd0);
    write_reg(cais_pkg::RegGridRows, 9'd2);
    for (int i = 0; i < 9; i++)
      push_cell(i == 0, i == 4 ? cais_pkg::StSusceptible : cais_pkg::StInfected, 16'hFFFF,
                i == 4 ? 16'h0000 : 16'hFFFF);
    for (int i = 0; i < 9; i++)
      push_cell(i == 0, i == 4 ? cais_pkg::StSusceptible : cais_pkg::StAsymptomatic,
                rand_frac(), i == 4 ? 16'hFFFF : 16'h0000);
    for (int i = 0; i < 9; i++)
      push_cell(i == 0, i == 4 ? cais_pkg::StSusceptible : 4'(i * 2 + (i > 4 ? 5 : 0)),
                16'hFFFF, 16'h8000);
    frames += 3;
    run_phase(9'd511, 9'd3);
    run_phase(9'd3, 9'd256);
    while (cells_sent + pending_cells.size() < 2000) begin
      k = $urandom_range(0, 19);
      c = 9'($urandom_range(3, 12));
      r = 9'($urandom_range(3, 12));
      if (k == 0) c = 9'($urandom_range(0, 2));
      if (k == 1) r = 9'($urandom_range(0, 2));
      if (k == 2) begin
        c = 9'($urandom_range(257, 511));
        r = 9'd3;
      end
      run_phase(c, r);
    end
    drain();
    $display("Sent %0d cells in %0d frames; checked %0d words, %0d of them susceptible.",
             cells_sent, frames, words_seen, sus_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout");
    $display("Verification failed");
    $finish;
  end

endmodule
